FILE: sv/polygon_edge_indexer_macros.svh
// Assertion macros used by the checker file.
`ifndef POLYGON_EDGE_INDEXER_MACROS_SVH
`define POLYGON_EDGE_INDEXER_MACROS_SVH

// Condition in one cycle implies consequence in the next cycle.
`define PEL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Condition implies consequence in the same cycle.
`define PEL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: sv/pel_pkg.sv
`timescale 1ns / 1ps

package pel_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_EDGES_DEF  = 4096;
    localparam int POINT_BITS_DEF = 16;

    // Fixed port field widths
    localparam int EDGE_ID_W = 12;
    localparam int PT_W      = 16;

    // Operation codes
    localparam logic OP_VERTEX = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Multiplicative hash constant (odd, golden ratio)
    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

    typedef struct packed {
        logic            operation;
        logic [PT_W-1:0] vertex_index;
        logic            last_vertex;
    } t_in_item;

    typedef struct packed {
        logic [EDGE_ID_W-1:0] edge_id;
        logic [PT_W-1:0]      point_a;
        logic [PT_W-1:0]      point_b;
        logic                 is_new;
        logic                 table_full;
        logic                 closes_polygon;
        logic                 last;
    } t_out_item;

endpackage

FILE: sv/pel_ram.sv
`timescale 1ns / 1ps

module pel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/pel_hash.sv
`timescale 1ns / 1ps

// Two-stage hash of an ordered point pair into a table slot.
module pel_hash #(
    parameter int PB = 16,
    parameter int HB = 13
) (
    input  logic          i_clk,
    input  logic [PB-1:0] i_lo,
    input  logic [PB-1:0] i_hi,
    output logic [HB-1:0] o_slot
);

    localparam int NCH = (32 + HB - 1) / HB;

    logic [31:0]   r_mix;
    logic [31:0]   r_lo;
    logic [HB-1:0] r_slot;
    logic [31:0]   mixed;
    logic [HB-1:0] folded;

    // Stage 1: scramble the larger endpoint
    always_ff @(posedge i_clk) begin
        r_mix <= 32'(i_hi) * pel_pkg::HASH_MULT;
        r_lo  <= 32'(i_lo);
    end

    // Stage 2: merge in the smaller endpoint and fold down to the slot width
    always_comb begin
        mixed  = r_mix ^ {r_lo[15:0], r_lo[31:16]} ^ r_lo;
        folded = '0;
        for (int i = 0; i < NCH; i++) begin
            folded = folded ^ HB'(mixed >> (i * HB));
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= folded;
    end

    assign o_slot = r_slot;

endmodule

FILE: sv/polygon_edge_indexer.sv
`timescale 1ns / 1ps

// Polygon edge indexer. Vertex items come in one at a time; each forms the edge from
// the previous vertex, and a vertex flagged last also forms the wrap edge back to the
// polygon's first vertex. Every edge gets one result item: its dense id, the endpoints
// as first stored, and new / full / closing / last flags. Edges are found through an
// open-addressed hash table with at least twice as many slots as MAX_EDGES and linear
// probing, whose slots point into an edge memory of MAX_EDGES entries; a slot counts as
// occupied only if its id is below the edge count and that edge points back at it, so
// neither memory needs clearing and a clear item only resets the edge count and the
// polygon state. The input is ready only when the sequencer is idle. Each edge passes
// through the setup, hash, load, read and check states, going back to the read state
// for every extra probe, and its final check waits while a stalled receiver holds the
// result register.
// Each probe is bounded by the two dependent memory reads: hash slot, then edge entry.
// A result waits in an output register, so the next item is taken while it is pending.
module polygon_edge_indexer #(
    parameter int MAX_EDGES        = pel_pkg::MAX_EDGES_DEF,
    parameter int POINT_INDEX_BITS = pel_pkg::POINT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pel_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pel_pkg::t_out_item  o_out_item
);

    localparam int P   = POINT_INDEX_BITS;
    localparam int IDW = $clog2(MAX_EDGES);
    localparam int CW  = $clog2(MAX_EDGES + 1);
    localparam int HB  = $clog2(MAX_EDGES) + 1;
    localparam int HD  = 2 ** HB;
    localparam int EW  = 2 * P + HB;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_RDE   = 3'd4;
    localparam logic [2:0] S_CHECK = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [P-1:0]       r_first, n_first;
    logic [P-1:0]       r_prev, n_prev;
    logic               r_inside, n_inside;
    logic [P-1:0]       r_p1, n_p1;
    logic [P-1:0]       r_p2, n_p2;
    logic [P-1:0]       r_lo, n_lo;
    logic [P-1:0]       r_hi, n_hi;
    logic               r_closes, n_closes;
    logic               r_pend, n_pend;
    logic [P-1:0]       r_v, n_v;
    logic [P-1:0]       r_w, n_w;
    logic [HB-1:0]      r_slot, n_slot;
    logic [IDW-1:0]     r_id, n_id;
    logic               r_id_ok, n_id_ok;
    logic               r_out_valid, n_out_valid;
    pel_pkg::t_out_item r_out, n_out;

    logic [HB-1:0]  hash_slot;
    logic [HB-1:0]  hash_raddr;
    logic [IDW-1:0] hash_rdata;
    logic           hash_we;
    logic [EW-1:0]  edge_rdata;
    logic           edge_we;

    // Slot index -> edge id
    pel_ram #(
        .WIDTH (IDW),
        .DEPTH (HD)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (hash_we),
        .i_waddr (r_slot),
        .i_wdata (IDW'(r_count)),
        .i_raddr (hash_raddr),
        .o_rdata (hash_rdata)
    );

    // Edge id -> {point a, point b, owning slot}
    pel_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (IDW'(r_count)),
        .i_wdata ({r_p1, r_p2, r_slot}),
        .i_raddr (hash_rdata),
        .o_rdata (edge_rdata)
    );

    pel_hash #(
        .PB (P),
        .HB (HB)
    ) u_hash (
        .i_clk  (i_clk),
        .i_lo   (r_lo),
        .i_hi   (r_hi),
        .o_slot (hash_slot)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Sequencer
    always_comb begin
        logic [P-1:0]  v;
        logic [P-1:0]  fv;
        logic [P-1:0]  sa;
        logic [P-1:0]  sb;
        logic [HB-1:0] sslot;
        logic [P-1:0]  s_lo;
        logic [P-1:0]  s_hi;
        logic          owned;
        logic          match;
        logic          full;
        logic          out_free;

        v        = P'(i_in_item.vertex_index);
        fv       = r_inside ? r_first : v;
        {sa, sb, sslot} = edge_rdata;
        s_lo     = (sa < sb) ? sa : sb;
        s_hi     = (sa < sb) ? sb : sa;
        owned    = r_id_ok && (sslot == r_slot);
        match    = (s_lo == r_lo) && (s_hi == r_hi);
        full     = (r_count == CW'(MAX_EDGES));
        out_free = !r_out_valid || i_out_ready;

        n_state     = r_state;
        n_count     = r_count;
        n_first     = r_first;
        n_prev      = r_prev;
        n_inside    = r_inside;
        n_p1        = r_p1;
        n_p2        = r_p2;
        n_closes    = r_closes;
        n_pend      = r_pend;
        n_v         = r_v;
        n_w         = r_w;
        n_slot      = r_slot;
        n_id        = r_id;
        n_id_ok     = r_id_ok;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        // keep reading the current slot so both memory outputs hold while a check waits
        hash_raddr  = r_slot;
        hash_we     = 1'b0;
        edge_we     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_item.operation == pel_pkg::OP_CLEAR) begin
                        n_count  = '0;
                        n_first  = '0;
                        n_prev   = '0;
                        n_inside = 1'b0;
                    end else begin
                        n_first  = fv;
                        n_prev   = v;
                        n_inside = !i_in_item.last_vertex;
                        n_v      = v;
                        n_w      = fv;
                        if (r_inside) begin
                            // edge from previous vertex; wrap edge may follow
                            n_p1     = r_prev;
                            n_p2     = v;
                            n_closes = 1'b0;
                            n_pend   = i_in_item.last_vertex;
                            n_state  = S_SETUP;
                        end else if (i_in_item.last_vertex) begin
                            // one-vertex polygon: wrap edge (v, v)
                            n_p1     = v;
                            n_p2     = fv;
                            n_closes = 1'b1;
                            n_pend   = 1'b0;
                            n_state  = S_SETUP;
                        end
                    end
                end
            end
            S_SETUP: begin
                n_state = S_HASH;
            end
            S_HASH: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                hash_raddr = hash_slot;
                n_slot     = hash_slot;
                n_state    = S_RDE;
            end
            S_RDE: begin
                n_id    = hash_rdata;
                n_id_ok = (CW'(hash_rdata) < r_count);
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (owned && !match) begin
                    // slot taken by another edge: probe the next one
                    hash_raddr = r_slot + 1'b1;
                    n_slot     = r_slot + 1'b1;
                    n_state    = S_RDE;
                end else if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.closes_polygon = r_closes;
                    n_out.last           = !r_pend;
                    if (owned) begin
                        n_out.edge_id    = pel_pkg::EDGE_ID_W'(r_id);
                        n_out.point_a    = pel_pkg::PT_W'(sa);
                        n_out.point_b    = pel_pkg::PT_W'(sb);
                        n_out.is_new     = 1'b0;
                        n_out.table_full = 1'b0;
                    end else if (!full) begin
                        hash_we          = 1'b1;
                        edge_we          = 1'b1;
                        n_count          = r_count + 1'b1;
                        n_out.edge_id    = pel_pkg::EDGE_ID_W'(r_count);
                        n_out.point_a    = pel_pkg::PT_W'(r_p1);
                        n_out.point_b    = pel_pkg::PT_W'(r_p2);
                        n_out.is_new     = 1'b1;
                        n_out.table_full = 1'b0;
                    end else begin
                        n_out.edge_id    = '0;
                        n_out.point_a    = pel_pkg::PT_W'(r_p1);
                        n_out.point_b    = pel_pkg::PT_W'(r_p2);
                        n_out.is_new     = 1'b0;
                        n_out.table_full = 1'b1;
                    end
                    if (r_pend) begin
                        n_p1     = r_v;
                        n_p2     = r_w;
                        n_closes = 1'b1;
                        n_pend   = 1'b0;
                        n_state  = S_SETUP;
                    end else begin
                        n_state  = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Orientation-free key of the current edge
        n_lo = (n_p1 < n_p2) ? n_p1 : n_p2;
        n_hi = (n_p1 < n_p2) ? n_p2 : n_p1;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_first     <= '0;
            r_prev      <= '0;
            r_inside    <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_first     <= n_first;
            r_prev      <= n_prev;
            r_inside    <= n_inside;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_p1     <= n_p1;
        r_p2     <= n_p2;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_closes <= n_closes;
        r_v      <= n_v;
        r_w      <= n_w;
        r_slot   <= n_slot;
        r_id     <= n_id;
        r_id_ok  <= n_id_ok;
        r_out    <= n_out;
    end

endmodule

FILE: sv/pel_checker.sv
`timescale 1ns / 1ps

`include "polygon_edge_indexer_macros.svh"

module pel_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input pel_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input pel_pkg::t_out_item o_out_item
);

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // A stalled result item holds
    `PEL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item), "result item changed while stalled")

    // Clear finishes at once
    `PEL_ASSERT_NEXT(a_clear_fast, i_clk, i_rst_n, in_acc && (i_in_item.operation == pel_pkg::OP_CLEAR), o_in_ready, "not ready after clear")

    // A closing vertex always starts edge work
    `PEL_ASSERT_NEXT(a_close_busy, i_clk, i_rst_n, in_acc && (i_in_item.operation == pel_pkg::OP_VERTEX) && i_in_item.last_vertex, !o_in_ready, "closing vertex made no edge work")

    // A full-table result is never new and carries id zero
    `PEL_ASSERT_SAME(a_full_flags, i_clk, i_rst_n, o_out_valid && o_out_item.table_full, !o_out_item.is_new && (o_out_item.edge_id == '0), "bad full-table result")

endmodule

bind polygon_edge_indexer pel_checker u_pel_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
